### src/ptx_pkg.sv
package ptx_pkg;

	localparam int CORDIC_ITERS = 24;
	localparam int ITER_W = $clog2(CORDIC_ITERS + 1);
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	typedef enum logic [2:0] {
		REG_ROT = 3'd0,
		REG_CX  = 3'd1,
		REG_CY  = 3'd2,
		REG_CZ  = 3'd3,
		REG_SX  = 3'd4,
		REG_SY  = 3'd5,
		REG_SZ  = 3'd6
	} reg_idx_t;

	// atan(2^-i), 2^32 per full turn
	function automatic logic signed [33:0] atan_turn(input logic [ITER_W-1:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### src/point_rigid_transform_xyz_core.sv
// Rigid point transform: each transfer carries one point (x, y, z packed in
// s_tdata, x lowest), which is moved to the configured centre, rotated about
// X, Y then Z, moved back, translated and saturated. One point per cycle is
// accepted unless the output stalls or the trig units are busy. There are
// eight register stages (centre subtract, two stages per axis rotation for
// the multiply and the round, final add and saturate). A low m_tready with
// m_tvalid high freezes the whole pipeline. Writing rot_angles starts three
// CORDIC units that need 24 iterations; s_tready is low while their start is
// pending and while they iterate. The overflow flag travels in m_tuser.
module point_rigid_transform_xyz_core #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,   // in_x, in_y, in_z
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,   // out_x, out_y, out_z
	output logic                  m_tuser,   // overflow
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [((3 * ANGLE_WIDTH > COORD_WIDTH) ? 3 * ANGLE_WIDTH : COORD_WIDTH) - 1:0]
		cfg_wdata
);
	import ptx_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int AW   = ANGLE_WIDTH;
	localparam int DW   = ((3 * CW + 7) / 8) * 8;
	localparam int TF   = ((60 - CW) < 30) ? (60 - CW) : 30;
	localparam int W    = CW + 3;

	logic [3*AW-1:0]        rot_q;
	logic signed [CW-1:0]   cx_q, cy_q, cz_q, sx_q, sy_q, sz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROT: rot_q <= cfg_wdata[3*AW-1:0];
				REG_CX:  cx_q  <= cfg_wdata[CW-1:0];
				REG_CY:  cy_q  <= cfg_wdata[CW-1:0];
				REG_CZ:  cz_q  <= cfg_wdata[CW-1:0];
				REG_SX:  sx_q  <= cfg_wdata[CW-1:0];
				REG_SY:  sy_q  <= cfg_wdata[CW-1:0];
				REG_SZ:  sz_q  <= cfg_wdata[CW-1:0];
				default: ;
			endcase
		end
	end

	logic start_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= 1'b0;
		else         start_q <= cfg_we && (cfg_idx == REG_ROT);
	end

	logic [2:0]            busy, zero;
	logic signed [TF+1:0]  sn [3];
	logic signed [TF+1:0]  cs [3];

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_trig
			ptx_cordic #(.AW(AW), .TF(TF)) u_cordic (
				.clk(clk), .arst_n(arst_n), .start(start_q),
				.angle(rot_q[g*AW +: AW]), .busy(busy[g]), .zero(zero[g]),
				.sin_o(sn[g]), .cos_o(cs[g])
			);
		end
	endgenerate

	logic trig_busy;
	logic en;
	logic v_s8;
	assign trig_busy = (|busy) | start_q;
	assign en        = !v_s8 || m_tready;
	assign s_tready  = en && !trig_busy;

	logic                 v_s1;
	logic signed [W-1:0]  x_s1, y_s1, z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  v_s1 <= 1'b0;
		else if (en)  v_s1 <= s_tvalid && s_tready;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= W'(signed'(s_tdata[CW-1:0]))      - W'(cx_q);
			y_s1 <= W'(signed'(s_tdata[2*CW-1:CW]))   - W'(cy_q);
			z_s1 <= W'(signed'(s_tdata[3*CW-1:2*CW])) - W'(cz_q);
		end
	end

	logic                v_s3, v_s5, v_s7;
	logic signed [W-1:0] x_s3, y_s3, z_s3, x_s5, y_s5, z_s5, x_s7, y_s7, z_s7;

	ptx_rot #(.W(W), .TF(TF)) u_rot_x (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s1),
		.a(y_s1), .b(z_s1), .p(x_s1), .s(sn[0]), .c(cs[0]), .zero(zero[0]),
		.vout(v_s3), .a_o(y_s3), .b_o(z_s3), .p_o(x_s3)
	);

	ptx_rot #(.W(W), .TF(TF)) u_rot_y (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s3),
		.a(z_s3), .b(x_s3), .p(y_s3), .s(sn[1]), .c(cs[1]), .zero(zero[1]),
		.vout(v_s5), .a_o(z_s5), .b_o(x_s5), .p_o(y_s5)
	);

	ptx_rot #(.W(W), .TF(TF)) u_rot_z (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s5),
		.a(x_s5), .b(y_s5), .p(z_s5), .s(sn[2]), .c(cs[2]), .zero(zero[2]),
		.vout(v_s7), .a_o(x_s7), .b_o(y_s7), .p_o(z_s7)
	);

	localparam logic signed [W+1:0] HI = (W+2)'((64'sd1 <<< (CW - 1)) - 1);
	localparam logic signed [W+1:0] LO = -HI - 1;

	logic signed [W+1:0] fx, fy, fz;
	logic                ox, oy, oz;
	logic [CW-1:0]       rx, ry, rz;

	assign fx = (W+2)'(x_s7) + (W+2)'(cx_q) + (W+2)'(sx_q);
	assign fy = (W+2)'(y_s7) + (W+2)'(cy_q) + (W+2)'(sy_q);
	assign fz = (W+2)'(z_s7) + (W+2)'(cz_q) + (W+2)'(sz_q);
	assign ox = (fx > HI) || (fx < LO);
	assign oy = (fy > HI) || (fy < LO);
	assign oz = (fz > HI) || (fz < LO);
	assign rx = (fx > HI) ? HI[CW-1:0] : (fx < LO) ? LO[CW-1:0] : fx[CW-1:0];
	assign ry = (fy > HI) ? HI[CW-1:0] : (fy < LO) ? LO[CW-1:0] : fy[CW-1:0];
	assign rz = (fz > HI) ? HI[CW-1:0] : (fz < LO) ? LO[CW-1:0] : fz[CW-1:0];

	logic [3*CW-1:0] d_s8;
	logic            ovf_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  v_s8 <= 1'b0;
		else if (en)  v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s8   <= {rz, ry, rx};
			ovf_s8 <= ox | oy | oz;
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata  = DW'(d_s8);
	assign m_tuser  = ovf_s8;

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		trig_busy |-> !s_tready)
		else $error("input taken while trig units settle");

	a_start_src: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> $past(cfg_we && (cfg_idx == REG_ROT)))
		else $error("trig restart without angle write");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && v_s8 && !m_tready) |=> v_s8 && v_s7)
		else $error("pipeline lost an item on stall");
endmodule

### src/ptx_cordic.sv
module ptx_cordic #(
	parameter int AW = 16,
	parameter int TF = 28
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [AW-1:0]        angle,
	output logic                 busy,
	output logic                 zero,
	output logic signed [TF+1:0] sin_o,
	output logic signed [TF+1:0] cos_o
);
	import ptx_pkg::*;

	localparam int RS = 30 - TF;

	logic [31:0]              u;
	logic                     neg;
	logic signed [33:0]       z0;
	logic signed [32:0]       x_q, y_q;
	logic signed [33:0]       z_q;
	logic                     neg_q;
	logic [ITER_W-1:0]        cnt_q, i_q;
	logic signed [32:0]       dx, dy;
	logic signed [33:0]       xf, yf, xr, yr;

	assign u   = {angle, {(32-AW){1'b0}}};
	assign neg = u[31] ^ u[30];
	assign z0  = {{2{u[31] ^ neg}}, u[31] ^ neg, u[30:0]};
	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign busy = (cnt_q != '0);
	assign zero = (angle == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			i_q   <= '0;
		end else if (start) begin
			cnt_q <= ITER_W'(CORDIC_ITERS);
			i_q   <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			i_q   <= i_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= z0;
			neg_q <= neg;
		end else if (busy) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_turn(i_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_turn(i_q);
			end
		end
	end

	assign xf = neg_q ? -34'(x_q) : 34'(x_q);
	assign yf = neg_q ? -34'(y_q) : 34'(y_q);

	generate
		if (RS == 0) begin : g_norm
			assign xr = xf;
			assign yr = yf;
		end else begin : g_round
			assign xr = (xf + (34'sd1 <<< (RS - 1))) >>> RS;
			assign yr = (yf + (34'sd1 <<< (RS - 1))) >>> RS;
		end
	endgenerate

	assign cos_o = xr[TF+1:0];
	assign sin_o = yr[TF+1:0];
endmodule

### src/ptx_rot.sv
module ptx_rot #(
	parameter int W  = 35,
	parameter int TF = 28
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vin,
	input  logic signed [W-1:0]  a,
	input  logic signed [W-1:0]  b,
	input  logic signed [W-1:0]  p,
	input  logic signed [TF+1:0] s,
	input  logic signed [TF+1:0] c,
	input  logic                 zero,
	output logic                 vout,
	output logic signed [W-1:0]  a_o,
	output logic signed [W-1:0]  b_o,
	output logic signed [W-1:0]  p_o
);
	localparam int PW = W + TF + 2;

	logic                  v_s1;
	logic                  zero_s1;
	logic signed [W-1:0]   a_s1, b_s1, p_s1;
	logic signed [PW-1:0]  ac_s1, bs_s1, as_s1, bc_s1;
	logic signed [PW:0]    na, nb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			vout <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ac_s1   <= a * c;
			bs_s1   <= b * s;
			as_s1   <= a * s;
			bc_s1   <= b * c;
			a_s1    <= a;
			b_s1    <= b;
			p_s1    <= p;
			zero_s1 <= zero;
		end
	end

	assign na = (PW+1)'(ac_s1) - (PW+1)'(bs_s1) + ((PW+1)'(1) <<< (TF - 1));
	assign nb = (PW+1)'(as_s1) + (PW+1)'(bc_s1) + ((PW+1)'(1) <<< (TF - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			p_o <= p_s1;
			if (zero_s1) begin
				a_o <= a_s1;
				b_o <= b_s1;
			end else begin
				a_o <= W'(na >>> TF);
				b_o <= W'(nb >>> TF);
			end
		end
	end
endmodule
